@@ sv/assert_macros.svh @@
// Assertion macros for the port-level checker of the slab allocator.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define SCSA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked property that also holds through reset.
`define SCSA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

@@ sv/scsa_pkg.sv @@
// Package for the size class slab allocator: request/response structs,
// status codes, pool geometry and small constant functions. No dependencies.
package scsa_pkg;

  localparam int POOL_BYTES      = 4096;
  localparam int HEADER_BYTES    = 16;
  localparam int MAX_SLOTS       = 128;
  localparam int NUM_CLASSES     = 4;
  localparam int CLASS_GRAIN     = 16;
  localparam int LARGEST_REQUEST = 64;

  localparam int SIZE_W  = 8;
  localparam int CLS_W   = 3;
  localparam int SLOT_W  = 7;
  localparam int OFF_W   = 12;
  localparam int STAT_W  = 2;
  localparam int CIDX_W  = $clog2(NUM_CLASSES);
  localparam int POS_W   = $clog2(MAX_SLOTS);
  localparam int CNT_W   = $clog2(MAX_SLOTS + 1);
  localparam int ADDR_W  = CIDX_W + POS_W;
  localparam int DEPTH   = NUM_CLASSES * MAX_SLOTS;
  localparam int GRAIN_SH = $clog2(CLASS_GRAIN);
  localparam int BYTES_W = $clog2(NUM_CLASSES * CLASS_GRAIN + HEADER_BYTES + 1);
  localparam int PROD_W  = SLOT_W + BYTES_W;

  // Slots per class: pool bytes over slot bytes, capped at MAX_SLOTS
  localparam int RAW_C1 = POOL_BYTES / (1 * CLASS_GRAIN + HEADER_BYTES);
  localparam int RAW_C2 = POOL_BYTES / (2 * CLASS_GRAIN + HEADER_BYTES);
  localparam int RAW_C3 = POOL_BYTES / (3 * CLASS_GRAIN + HEADER_BYTES);
  localparam int RAW_C4 = POOL_BYTES / (4 * CLASS_GRAIN + HEADER_BYTES);
  localparam int SLOTS_C1 = (RAW_C1 > MAX_SLOTS) ? MAX_SLOTS : RAW_C1;
  localparam int SLOTS_C2 = (RAW_C2 > MAX_SLOTS) ? MAX_SLOTS : RAW_C2;
  localparam int SLOTS_C3 = (RAW_C3 > MAX_SLOTS) ? MAX_SLOTS : RAW_C3;
  localparam int SLOTS_C4 = (RAW_C4 > MAX_SLOTS) ? MAX_SLOTS : RAW_C4;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] ST_ALLOC_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_ALLOC_FAIL = 2'd1;
  localparam logic [STAT_W-1:0] ST_FREED      = 2'd2;
  localparam logic [STAT_W-1:0] ST_FREE_REJ   = 2'd3;

  typedef struct packed {
    logic              action;
    logic [SIZE_W-1:0] request_size;
    logic [CLS_W-1:0]  free_class;
    logic [SLOT_W-1:0] free_slot;
  } req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [CLS_W-1:0]  block_class;
    logic [SLOT_W-1:0] block_slot;
    logic [OFF_W-1:0]  payload_offset;
  } rsp_t;

  // Slot count of a class, by zero-based class index
  function automatic logic [CNT_W-1:0] slot_count(input logic [CIDX_W-1:0] k);
    logic [CNT_W-1:0] n;
    case (k)
      2'd0:    n = CNT_W'(SLOTS_C1);
      2'd1:    n = CNT_W'(SLOTS_C2);
      2'd2:    n = CNT_W'(SLOTS_C3);
      default: n = CNT_W'(SLOTS_C4);
    endcase
    return n;
  endfunction

  // Slot stride in bytes for class c (1..4)
  function automatic logic [BYTES_W-1:0] slot_bytes(input logic [CLS_W-1:0] c);
    logic [BYTES_W-1:0] b;
    b = BYTES_W'({c, {GRAIN_SH{1'b0}}}) + BYTES_W'(HEADER_BYTES);
    return b;
  endfunction

endpackage

@@ sv/size_class_slab_allocator.sv @@
// Top level of the size class slab allocator: decode, per-class counters
// and the slot stack RAM (scsa_ram). Uses scsa_pkg.
//
//  port group          dir  handshake            payload
//  start_i / busy_o    in   start_i && !busy_o   req_i (req_t)
//  rsp_valid_o         out  one-cycle strobe     rsp_o (rsp_t)
//
// A request is taken at an edge with start_i high and busy_o low; its
// response strobes from the response register after stage 1. busy_o is high
// the cycle after a request (RAM read of the stack top) and blocks a new one.
// Reset fills every stack logically (fill marks, no clearing pass).
// The response cannot be stalled.
module size_class_slab_allocator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  scsa_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output scsa_pkg::rsp_t rsp_o
);
  import scsa_pkg::*;

  logic                  accept;
  logic [CNT_W-1:0]      count_q [NUM_CLASSES];
  logic [CNT_W-1:0]      count_d [NUM_CLASSES];
  // lowest stack position ever written per class; below it the reset content holds
  logic [CNT_W-1:0]      low_q [NUM_CLASSES];
  logic [CNT_W-1:0]      low_d [NUM_CLASSES];

  logic                  size_ok;
  logic [SIZE_W:0]       size_sum;
  logic [CLS_W-1:0]      alloc_cls;
  logic                  fcls_ok;
  logic [CIDX_W-1:0]     k;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      nslots;
  logic [POS_W-1:0]      pos;

  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [SLOT_W-1:0]     ram_wdata;
  logic [SLOT_W-1:0]     ram_rdata;

  // stage 1 (RAM read in flight)
  logic                  s1_q;
  logic [STAT_W-1:0]     st_q, st_d;
  logic [CLS_W-1:0]      cls_q, cls_d;
  logic [SLOT_W-1:0]     slot_q, slot_d;
  logic                  pop_q, pop_d;
  logic                  wr_q, wr_d;
  logic [SLOT_W-1:0]     rstv_q, rstv_d;

  logic [SLOT_W-1:0]     slot_sel;
  logic [PROD_W-1:0]     prod;
  logic [OFF_W-1:0]      offset;

  logic                  rsp_valid_q;
  rsp_t                  rsp_q;

  assign accept   = start_i && !busy_o;
  assign busy_o   = s1_q;

  assign size_ok  = (req_i.request_size != '0) &&
                    (req_i.request_size <= SIZE_W'(LARGEST_REQUEST));
  assign size_sum = {1'b0, req_i.request_size} + (SIZE_W+1)'(CLASS_GRAIN - 1);
  assign alloc_cls = CLS_W'(size_sum >> GRAIN_SH);
  assign fcls_ok  = (req_i.free_class != '0) &&
                    (req_i.free_class <= CLS_W'(NUM_CLASSES));

  // one class index drives the counter read, whichever the action
  always_comb begin
    if (req_i.action == ACT_FREE) begin
      k = CIDX_W'(req_i.free_class - CLS_W'(1));
    end else begin
      k = CIDX_W'(alloc_cls - CLS_W'(1));
    end
  end

  assign cnt    = count_q[k];
  assign nslots = slot_count(k);

  always_comb begin
    count_d   = count_q;
    low_d     = low_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    pos       = '0;
    ram_waddr = {k, req_i.free_slot[POS_W-1:0] & '0};
    ram_raddr = '0;
    ram_wdata = req_i.free_slot;
    st_d      = ST_ALLOC_FAIL;
    cls_d     = '0;
    slot_d    = '0;
    pop_d     = 1'b0;
    wr_d      = 1'b0;
    rstv_d    = '0;
    case (req_i.action)
      ACT_ALLOC: begin
        if (!size_ok) begin
          st_d  = ST_ALLOC_FAIL;
        end else if (cnt == '0) begin
          st_d  = ST_ALLOC_FAIL;
          cls_d = alloc_cls;
        end else begin
          pos        = POS_W'(cnt - CNT_W'(1));
          ram_re     = accept;
          ram_raddr  = {k, pos};
          count_d[k] = cnt - CNT_W'(1);
          st_d       = ST_ALLOC_OK;
          cls_d      = alloc_cls;
          pop_d      = 1'b1;
          wr_d       = {1'b0, pos} >= low_q[k];
          rstv_d     = SLOT_W'(nslots - CNT_W'(1) - {1'b0, pos});
        end
      end
      ACT_FREE: begin
        slot_d = req_i.free_slot;
        if (!fcls_ok) begin
          st_d = ST_FREE_REJ;
        end else if (({1'b0, req_i.free_slot} >= nslots) || (cnt >= nslots)) begin
          st_d  = ST_FREE_REJ;
          cls_d = req_i.free_class;
        end else begin
          pos        = cnt[POS_W-1:0];
          ram_we     = accept;
          ram_waddr  = {k, pos};
          count_d[k] = cnt + CNT_W'(1);
          if (cnt < low_q[k]) begin
            low_d[k] = cnt;
          end
          st_d  = ST_FREED;
          cls_d = req_i.free_class;
        end
      end
      default: begin
        st_d = ST_ALLOC_FAIL;
      end
    endcase
  end

  scsa_ram #(
    .DEPTH (DEPTH),
    .WIDTH (SLOT_W)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= 1'b0;
      for (int unsigned i = 0; i < NUM_CLASSES; i++) begin
        count_q[i] <= slot_count(CIDX_W'(i));
        low_q[i]   <= slot_count(CIDX_W'(i));
      end
    end else begin
      s1_q <= accept;
      if (accept) begin
        count_q <= count_d;
        low_q   <= low_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q   <= st_d;
      cls_q  <= cls_d;
      slot_q <= slot_d;
      pop_q  <= pop_d;
      wr_q   <= wr_d;
      rstv_q <= rstv_d;
    end
  end

  // a never-written stack entry still holds its reset slot
  assign slot_sel = pop_q ? (wr_q ? ram_rdata : rstv_q) : slot_q;
  assign prod     = PROD_W'(slot_sel) * PROD_W'(slot_bytes(cls_q));

  always_comb begin
    if ((st_q == ST_ALLOC_OK) || (st_q == ST_FREED)) begin
      offset = OFF_W'(prod + PROD_W'(HEADER_BYTES));
    end else begin
      offset = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= s1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_q) begin
      rsp_q.status         <= st_q;
      rsp_q.block_class    <= cls_q;
      rsp_q.block_slot     <= slot_sel;
      rsp_q.payload_offset <= offset;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

@@ sv/scsa_ram.sv @@
// Simple dual-port RAM, one write and one registered read port.
// Used for the free slot stacks; no package dependency.
module scsa_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 7
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/scsa_checker.sv @@
// Port-level checker for the slab allocator, bound to the top level.
// Depends on scsa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module scsa_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start_i,
  input logic           busy_o,
  input scsa_pkg::req_t req_i,
  input logic           rsp_valid_o,
  input scsa_pkg::rsp_t rsp_o
);
  import scsa_pkg::*;

  `SCSA_ASSERT(a_busy_after_req, clk_i, rst_ni, start_i && !busy_o |=> busy_o, "no busy after request")
  `SCSA_ASSERT(a_rsp_follows, clk_i, rst_ni, start_i && !busy_o |-> ##2 rsp_valid_o, "response missing")
  `SCSA_ASSERT(a_rsp_has_req, clk_i, rst_ni, rsp_valid_o |-> $past(start_i && !busy_o, 2), "response without request")
  `SCSA_ASSERT(a_fail_zero, clk_i, rst_ni, rsp_valid_o && rsp_o.status == ST_ALLOC_FAIL |-> rsp_o.block_slot == '0 && rsp_o.payload_offset == '0, "failed alloc not zeroed")
  `SCSA_ASSERT_ALWAYS(a_rsp_not_busy, clk_i, rsp_valid_o |-> !busy_o, "busy during response")

endmodule

bind size_class_slab_allocator scsa_checker u_scsa_checker (.*);

@@ tb/scsa_checker.sv @@
// Checker for the size class slab allocator: watches requests and responses,
// keeps its own copy of the per-class free stacks and compares every response.
// Depends on scsa_pkg.
module scsa_scoreboard (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  scsa_pkg::req_t req_i,
  input  logic           rsp_valid_i,
  input  scsa_pkg::rsp_t rsp_i,
  output int             fail_count_o,
  output int             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import scsa_pkg::*;

  logic [SLOT_W-1:0] slot_stack [NUM_CLASSES][MAX_SLOTS];
  int unsigned       free_cnt [NUM_CLASSES];
  rsp_t              owed_rsp [$];
  int                miss_cnt = 0;

  assign fail_count_o = miss_cnt;

  function automatic int unsigned slots_of(int unsigned cls);
    int unsigned n;
    n = POOL_BYTES / (cls * CLASS_GRAIN + HEADER_BYTES);
    return (n > MAX_SLOTS) ? MAX_SLOTS : n;
  endfunction

  function automatic logic [OFF_W-1:0] payload_at(int unsigned cls, int unsigned slot);
    return OFF_W'(slot * (cls * CLASS_GRAIN + HEADER_BYTES) + HEADER_BYTES);
  endfunction

  // Pop or push one slot if the request succeeds, and return the response that the request earns.
  function automatic rsp_t serve(req_t r);
    rsp_t        o;
    int unsigned cls;
    int unsigned k;
    int unsigned n;
    o = '0;
    if (r.action == ACT_ALLOC) begin
      o.status = ST_ALLOC_FAIL;
      if (r.request_size != 0 && r.request_size <= LARGEST_REQUEST) begin
        cls = (int'(r.request_size) + CLASS_GRAIN - 1) / CLASS_GRAIN;
        k = cls - 1;
        o.block_class = CLS_W'(cls);
        if (free_cnt[k] != 0) begin
          free_cnt[k]--;
          o.status = ST_ALLOC_OK;
          o.block_slot = slot_stack[k][free_cnt[k]];
          o.payload_offset = payload_at(cls, o.block_slot);
        end
      end
    end else begin
      o.status = ST_FREE_REJ;
      o.block_slot = r.free_slot;
      if (r.free_class >= 1 && r.free_class <= NUM_CLASSES) begin
        cls = r.free_class;
        k = cls - 1;
        n = slots_of(cls);
        o.block_class = r.free_class;
        // double frees are pushed again as long as the stack has room
        if (r.free_slot < n && free_cnt[k] < n) begin
          slot_stack[k][free_cnt[k]] = r.free_slot;
          free_cnt[k]++;
          o.status = ST_FREED;
          o.payload_offset = payload_at(cls, r.free_slot);
        end
      end
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t        want;
    int unsigned n;
    if (!rst_ni) begin
      // full stacks, slot 0 on top
      for (int c = 0; c < NUM_CLASSES; c++) begin
        n = slots_of(c + 1);
        for (int i = 0; i < MAX_SLOTS; i++) begin
          slot_stack[c][i] = (i < n) ? SLOT_W'(n - 1 - i) : '0;
        end
        free_cnt[c] = n;
      end
      owed_rsp.delete();
    end else begin
      if (rsp_valid_i) begin
        if (owed_rsp.size() == 0) begin
          miss_cnt++;
          if (miss_cnt <= 10) begin
            $display("%0t: response with no request outstanding: st %0d cls %0d slot %0d off %0d",
                     $realtime, rsp_i.status, rsp_i.block_class, rsp_i.block_slot,
                     rsp_i.payload_offset);
          end
        end else begin
          want = owed_rsp.pop_front();
          if (rsp_i.status !== want.status || rsp_i.block_class !== want.block_class ||
              rsp_i.block_slot !== want.block_slot ||
              rsp_i.payload_offset !== want.payload_offset) begin
            miss_cnt++;
            if (miss_cnt <= 10) begin
              $display("%0t: mismatch exp st %0d cls %0d slot %0d off %0d, got st %0d cls %0d slot %0d off %0d",
                       $realtime, want.status, want.block_class, want.block_slot,
                       want.payload_offset, rsp_i.status, rsp_i.block_class,
                       rsp_i.block_slot, rsp_i.payload_offset);
            end
          end
        end
      end
      if (start_i && !busy_i) begin
        owed_rsp.push_back(serve(req_i));
      end
    end
    pending_o = owed_rsp.size();
  end

endmodule

@@ tb/size_class_slab_allocator_test.sv @@
// Top of the slab allocator testbench: clock, reset and request stimulus.
// Instantiates size_class_slab_allocator and scsa_scoreboard; uses scsa_pkg.
module size_class_slab_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import scsa_pkg::*;

  localparam int ITEMS       = 950;
  localparam int QUIET_TAIL  = 120;
  localparam int CYCLE_LIMIT = 200000;

  typedef enum int {FILL, DRAIN, MIXED} mode_e;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [SLOT_W-1:0] slot;
  } block_t;

  logic   clk_i   = 1'b0;
  logic   rst_ni  = 1'b0;
  logic   start_i = 1'b0;
  req_t   req_i   = '0;
  logic   busy_o;
  logic   rsp_valid_o;
  rsp_t   rsp_o;
  int     fail_count;
  int     pending;
  int     cycles = 0;
  int     sent = 0;
  bit     track = 1'b0;
  block_t held [$];
  block_t last_freed = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  size_class_slab_allocator uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .busy_o     (busy_o),
    .req_i      (req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_o      (rsp_o)
  );

  scsa_scoreboard chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_i      (busy_o),
    .req_i       (req_i),
    .rsp_valid_i (rsp_valid_o),
    .rsp_i       (rsp_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // remember live blocks so most frees hit slots that are really handed out
  always @(negedge clk_i) begin
    if (track && rsp_valid_o && rsp_o.status == ST_ALLOC_OK) begin
      held.push_back({rsp_o.block_class, rsp_o.block_slot});
    end
  end

  function automatic req_t alloc_req(int unsigned size);
    req_t r;
    r.action       = ACT_ALLOC;
    r.request_size = SIZE_W'(size);
    r.free_class   = CLS_W'($urandom);
    r.free_slot    = SLOT_W'($urandom);
    return r;
  endfunction

  function automatic req_t free_req(int unsigned cls, int unsigned slot);
    req_t r;
    r.action       = ACT_FREE;
    r.request_size = SIZE_W'($urandom);
    r.free_class   = CLS_W'(cls);
    r.free_slot    = SLOT_W'(slot);
    return r;
  endfunction

  function automatic int unsigned bad_size();
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(LARGEST_REQUEST + 1, 255);
  endfunction

  function automatic req_t free_held();
    int unsigned i;
    block_t      b;
    if (held.size() == 0) begin
      return alloc_req($urandom_range(1, LARGEST_REQUEST));
    end
    i = $urandom_range(0, held.size() - 1);
    b = held[i];
    held.delete(i);
    last_freed = b;
    return free_req(b.cls, b.slot);
  endfunction

  function automatic req_t pick_req(mode_e mode, int unsigned focus);
    int unsigned dice;
    req_t        r;
    dice = $urandom_range(0, 99);
    case (mode)
      FILL: begin
        if (dice < 70) r = alloc_req($urandom_range(focus * CLASS_GRAIN - 15,
                                                    focus * CLASS_GRAIN));
        else if (dice < 82) r = alloc_req($urandom_range(1, LARGEST_REQUEST));
        else if (dice < 87) r = alloc_req(bad_size());
        else r = free_held();
      end
      DRAIN: begin
        if (dice < 70) r = free_held();
        else if (dice < 80) r = free_req(last_freed.cls, last_freed.slot);
        else if (dice < 90) r = free_req($urandom_range(0, 7), $urandom_range(0, 127));
        else r = alloc_req($urandom_range(1, LARGEST_REQUEST));
      end
      default: begin
        if (dice < 45) r = alloc_req($urandom_range(1, LARGEST_REQUEST));
        else if (dice < 80) r = free_held();
        else if (dice < 88) r = free_req($urandom_range(0, 7), $urandom_range(0, 127));
        else if (dice < 94) r = alloc_req(bad_size());
        else r = free_req(last_freed.cls, last_freed.slot);
      end
    endcase
    return r;
  endfunction

  // called in the time step of a rising edge; returns at the accepting edge
  task automatic send(input req_t r);
    start_i <= 1'b1;
    req_i   <= r;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    sent++;
  endtask

  task automatic pause(int unsigned n);
    start_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_out();
    start_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    int    dir_sizes [];
    req_t  r;
    mode_e mode;
    int    focus;
    int    left;
    int    idle_pct;

    dir_sizes = '{0, 65, 255, 1, 16, 17, 32, 33, 48, 49, 64};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // size edges of every class plus zero and oversize requests
    foreach (dir_sizes[i]) send(alloc_req(dir_sizes[i]));
    // bad classes, double free, slots past the class end, frees to full stacks
    send(free_req(0, 127));
    send(free_req(5, 0));
    send(free_req(7, 85));
    send(free_req(1, 127));
    send(free_req(2, 85));
    send(free_req(4, 51));
    send(free_req(3, 127));
    send(free_req(4, 1));
    send(free_req(4, 1));
    send(free_req(4, 0));
    r = free_req(1, 0);
    r.request_size = 8'hFF;
    send(r);
    send(free_req(1, 1));

    drain_out();
    held.delete();
    last_freed = {3'd1, 7'd0};
    track = 1'b1;

    while (sent < ITEMS) begin
      mode     = mode_e'($urandom_range(0, 2));
      focus    = $urandom_range(1, NUM_CLASSES);
      left     = $urandom_range(40, 150);
      idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 12;
      while (left > 0 && sent < ITEMS) begin
        if (sent < ITEMS - QUIET_TAIL && $urandom_range(0, 99) < idle_pct) begin
          pause($urandom_range(1, 19));
        end
        send(pick_req(mode, focus));
        left--;
      end
    end

    drain_out();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
